FILE: hw/rtl/fsec_pkg.sv
// Shared types and constants for the find session event classifier.
// No dependencies; fsec_apb, fsec_engine and the top level import this package.
package fsec_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [31:0] ROUND_LEN_RESET = 32'd10000;
    localparam logic [31:0] SESSION_CAP_RESET = 32'd120000;
    localparam logic [15:0] SETTLE_RESET = 16'd50;
    localparam logic [7:0] ATTEMPT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        REG_ROUND_LEN = 2'd0,
        REG_SESSION_CAP = 2'd1,
        REG_SETTLE = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_CLASSIFY = 2'd0,
        ACT_VERDICT = 2'd1,
        ACT_STATUS = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PH_SEARCHING = 2'd0,
        PH_CONNECTED = 2'd1,
        PH_RINGING = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OUT_IN_PROGRESS = 2'd0,
        OUT_TIMED_OUT = 2'd1,
        OUT_BACK = 2'd2,
        OUT_DISMISSED = 2'd3
    } t_outcome;

    typedef enum logic [3:0] {
        EV_WAITING = 4'd0,
        EV_ENDED = 4'd1,
        EV_SOUND = 4'd2,
        EV_FIND = 4'd3,
        EV_CONNECT = 4'd4,
        EV_TIME = 4'd5,
        EV_SUBSCRIBE = 4'd6,
        EV_DISCONN = 4'd7,
        EV_ROUND = 4'd8,
        EV_NONE = 4'd9
    } t_event;

    typedef struct packed {
        logic [31:0] round_length_ms;
        logic [31:0] session_cap_ms;
        logic [15:0] button_settle_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [31:0] stamp_ms;
        logic menu_rise;
        logic menu_down;
        logic back_hit;
        logic find_wr;
        logic link_connected;
        logic time_wr;
        logic find_sub;
        logic link_dropped;
        logic write_ok;
    } t_item;

    typedef struct packed {
        t_event ev;
        t_outcome outcome;
        logic ended;
        t_phase phase;
        logic sound;
        logic [7:0] attempts;
        logic [31:0] now;
        logic [31:0] round_start;
        logic press_pending;
        logic [32:0] settle_time;
    } t_snap;

endpackage

FILE: hw/rtl/fsec_if.sv
// Valid/ready channel interfaces for the input item and the result item.
// No dependencies.
interface fsec_in_if;
    logic valid;
    logic ready;
    logic [1:0] action;
    logic [31:0] stamp_ms;
    logic menu_rise;
    logic menu_down;
    logic back_hit;
    logic find_wr;
    logic link_connected;
    logic time_wr;
    logic find_sub;
    logic link_dropped;
    logic write_ok;

    modport source (
        output valid, action, stamp_ms, menu_rise, menu_down, back_hit,
               find_wr, link_connected, time_wr, find_sub,
               link_dropped, write_ok,
        input ready
    );
    modport sink (
        input valid, action, stamp_ms, menu_rise, menu_down, back_hit,
              find_wr, link_connected, time_wr, find_sub,
              link_dropped, write_ok,
        output ready
    );
endinterface

interface fsec_out_if;
    logic valid;
    logic ready;
    logic [3:0] event_res;
    logic [1:0] outcome;
    logic session_ended;
    logic [1:0] link_phase;
    logic sound_on;
    logic [7:0] attempt_count;
    logic [31:0] wait_ms;

    modport source (
        output valid, event_res, outcome, session_ended, link_phase, sound_on,
               attempt_count, wait_ms,
        input ready
    );
    modport sink (
        input valid, event_res, outcome, session_ended, link_phase, sound_on,
              attempt_count, wait_ms,
        output ready
    );
endinterface

FILE: hw/rtl/fsec_apb.sv
// APB-style configuration registers: round length, session cap, settle delay.
// Depends on fsec_pkg.
module fsec_apb (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [fsec_pkg::ADDR_W-1:0] i_paddr,
    input  logic [fsec_pkg::DATA_W-1:0] i_pwdata,
    output logic [fsec_pkg::DATA_W-1:0] o_prdata,
    output logic                     o_pready,
    output fsec_pkg::t_cfg           o_cfg
);
    import fsec_pkg::*;

    logic [31:0] r_round_len;
    logic [31:0] r_cap;
    logic [15:0] r_settle;
    logic        wr_en;
    t_reg_idx    idx;

    assign idx = t_reg_idx'(i_paddr[3:2]);
    assign wr_en = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_len <= ROUND_LEN_RESET;
            r_cap <= SESSION_CAP_RESET;
            r_settle <= SETTLE_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_ROUND_LEN: r_round_len <= i_pwdata;
                REG_SESSION_CAP: r_cap <= i_pwdata;
                REG_SETTLE: r_settle <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ROUND_LEN: o_prdata = r_round_len;
            REG_SESSION_CAP: o_prdata = r_cap;
            REG_SETTLE: o_prdata = {16'd0, r_settle};
            default: o_prdata = '0;
        endcase
    end

    assign o_cfg = '{round_length_ms: r_round_len, session_cap_ms: r_cap,
                     button_settle_ms: r_settle};
endmodule

FILE: hw/rtl/fsec_engine.sv
// Session state and the priority classification of one registered item.
// Depends on fsec_pkg.
module fsec_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsec_pkg::t_cfg  i_cfg,
    input  logic            i_fire,
    input  fsec_pkg::t_item i_item,
    output fsec_pkg::t_snap o_snap
);
    import fsec_pkg::*;

    logic        r_ended, n_ended;
    t_outcome    r_outcome, n_outcome;
    t_phase      r_phase, n_phase;
    logic        r_sound, n_sound;
    logic [7:0]  r_attempts, n_attempts;
    logic [31:0] r_round_start, n_round_start;
    logic        r_pend, n_pend;
    logic [32:0] r_settle, n_settle;
    t_event      ev;
    logic [32:0] now33;
    logic [32:0] round_dl;
    logic        done;

    assign now33 = {1'b0, i_item.stamp_ms};
    assign round_dl = {1'b0, r_round_start} + {1'b0, i_cfg.round_length_ms};

    always_comb begin
        n_ended = r_ended;
        n_outcome = r_outcome;
        n_phase = r_phase;
        n_sound = r_sound;
        n_attempts = r_attempts;
        n_round_start = r_round_start;
        n_pend = r_pend;
        n_settle = r_settle;
        ev = EV_NONE;
        done = 1'b0;
        case (t_action'(i_item.action))
            ACT_CLASSIFY: begin
                if (r_ended) begin
                    ev = EV_ENDED;
                end else if (i_item.stamp_ms >= i_cfg.session_cap_ms) begin
                    n_ended = 1'b1;
                    n_outcome = OUT_TIMED_OUT;
                    ev = EV_ENDED;
                end else begin
                    if (i_item.menu_rise && !r_pend && r_phase != PH_SEARCHING) begin
                        n_pend = 1'b1;
                        n_settle = now33 + {17'd0, i_cfg.button_settle_ms};
                    end
                    if (i_item.back_hit) begin
                        n_ended = 1'b1;
                        n_outcome = OUT_BACK;
                        ev = EV_ENDED;
                    end else begin
                        if (n_pend && now33 >= n_settle) begin
                            n_pend = 1'b0;
                            n_settle = '0;
                            if (i_item.menu_down && r_phase != PH_SEARCHING) begin
                                n_sound = !r_sound;
                                n_round_start = i_item.stamp_ms;
                                ev = EV_SOUND;
                                done = 1'b1;
                            end
                        end
                        if (!done) begin
                            if (i_item.find_wr) begin
                                n_round_start = i_item.stamp_ms;
                                ev = EV_FIND;
                            end else if (r_phase == PH_SEARCHING && i_item.link_connected) begin
                                n_phase = PH_CONNECTED;
                                n_round_start = i_item.stamp_ms;
                                ev = EV_CONNECT;
                            end else if (r_phase != PH_SEARCHING && i_item.time_wr) begin
                                n_round_start = i_item.stamp_ms;
                                ev = EV_TIME;
                            end else if (i_item.find_sub) begin
                                n_round_start = i_item.stamp_ms;
                                ev = EV_SUBSCRIBE;
                            end else if (i_item.link_dropped) begin
                                if (r_phase != PH_SEARCHING && r_attempts != ATTEMPT_MAX)
                                    n_attempts = r_attempts + 8'd1;
                                n_phase = PH_SEARCHING;
                                n_pend = 1'b0;
                                n_settle = '0;
                                n_round_start = i_item.stamp_ms;
                                ev = EV_DISCONN;
                            end else if (i_item.time_wr) begin
                                n_phase = PH_CONNECTED;
                                n_round_start = i_item.stamp_ms;
                                ev = EV_TIME;
                            end else if (now33 >= round_dl) begin
                                n_round_start = i_item.stamp_ms;
                                if (r_phase == PH_SEARCHING && r_attempts != ATTEMPT_MAX)
                                    n_attempts = r_attempts + 8'd1;
                                ev = EV_ROUND;
                            end else begin
                                ev = EV_WAITING;
                            end
                        end
                    end
                end
            end
            ACT_VERDICT: begin
                if (!r_ended && i_item.write_ok) begin
                    n_ended = 1'b1;
                    n_outcome = OUT_DISMISSED;
                end
            end
            ACT_STATUS: begin
                if (!r_ended && r_phase == PH_CONNECTED)
                    n_phase = PH_RINGING;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
            r_outcome <= OUT_IN_PROGRESS;
            r_phase <= PH_SEARCHING;
            r_sound <= 1'b0;
            r_attempts <= '0;
            r_round_start <= '0;
            r_pend <= 1'b0;
            r_settle <= '0;
        end else if (i_fire) begin
            r_ended <= n_ended;
            r_outcome <= n_outcome;
            r_phase <= n_phase;
            r_sound <= n_sound;
            r_attempts <= n_attempts;
            r_round_start <= n_round_start;
            r_pend <= n_pend;
            r_settle <= n_settle;
        end
    end

    assign o_snap = '{ev: ev, outcome: n_outcome, ended: n_ended, phase: n_phase,
                      sound: n_sound, attempts: n_attempts, now: i_item.stamp_ms,
                      round_start: n_round_start, press_pending: n_pend,
                      settle_time: n_settle};

    a_ended_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |=> r_ended)
        else $error("ended flag cleared without reset");

    a_outcome_with_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outcome != OUT_IN_PROGRESS) == r_ended)
        else $error("outcome and ended flag disagree");

    a_sound_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && ev == EV_SOUND |=> r_sound != $past(r_sound))
        else $error("sound event without sound flag change");

    a_attempts_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> r_attempts >= $past(r_attempts))
        else $error("attempt count went down");
endmodule

FILE: hw/rtl/find_session_event_classifier.sv
// Top level of the find session event classifier: channels, pipeline, wait stage.
// Depends on fsec_pkg, fsec_if, fsec_apb and fsec_engine.
//
// Usage:
//   i_in carries one item per transfer (valid and ready both high at a clock
//   edge). o_out returns exactly one result per item, in order.
//   The APB-style port holds round length, session cap and settle delay; write
//   them only while no item is in flight. pready is always high.
//   Pipeline: input register, classification stage (updates session state),
//   wait stage (next deadline minus timestamp) into the result register.
//   Order: the transfer itself loads the input register, the classification
//   result is then registered, and the wait stage fills the result register.
//   Throughput: one item per cycle when not stalled; the session state loop
//   closes in the single classification stage, so consecutive items need no gap.
//   Stall: when o_out.ready is low with a result waiting, all three stages
//   hold and i_in.ready drops in the same cycle; nothing is lost.
//   Reset (i_rst_n low, synchronous): pipeline empties, session returns to
//   searching with no outcome, registers take their default values.
module find_session_event_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fsec_in_if.sink                     i_in,
    fsec_out_if.source                  o_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [fsec_pkg::ADDR_W-1:0] i_paddr,
    input  logic [fsec_pkg::DATA_W-1:0] i_pwdata,
    output logic [fsec_pkg::DATA_W-1:0] o_prdata,
    output logic                        o_pready
);
    import fsec_pkg::*;

    t_cfg        cfg;
    t_item       item_in;
    t_item       r_s1;
    logic        r_v1, r_v2, r_v3;
    t_snap       snap, r_s2;
    logic        en;
    logic        fire;
    logic [32:0] dl_a, dl_b, dl;
    logic [32:0] now33;
    logic [31:0] n_wait;
    logic [31:0] r_wait;
    t_event      r_ev;
    t_outcome    r_outcome;
    logic        r_ended;
    t_phase      r_phase;
    logic        r_sound;
    logic [7:0]  r_attempts;

    fsec_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    assign en = !r_v3 || o_out.ready;
    assign i_in.ready = en;
    assign fire = en && r_v1;

    assign item_in = '{action: i_in.action, stamp_ms: i_in.stamp_ms,
                       menu_rise: i_in.menu_rise, menu_down: i_in.menu_down,
                       back_hit: i_in.back_hit, find_wr: i_in.find_wr,
                       link_connected: i_in.link_connected,
                       time_wr: i_in.time_wr,
                       find_sub: i_in.find_sub,
                       link_dropped: i_in.link_dropped, write_ok: i_in.write_ok};

    fsec_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_item  (r_s1),
        .o_snap  (snap)
    );

    always_comb begin
        now33 = {1'b0, r_s2.now};
        dl_a = {1'b0, r_s2.round_start} + {1'b0, cfg.round_length_ms};
        dl_b = ({1'b0, cfg.session_cap_ms} < dl_a) ? {1'b0, cfg.session_cap_ms} : dl_a;
        dl = (r_s2.press_pending && r_s2.settle_time < dl_b) ? r_s2.settle_time : dl_b;
        if (r_s2.ended || now33 >= dl)
            n_wait = '0;
        else
            n_wait = 32'(dl - now33);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= item_in;
            r_s2 <= snap;
            r_wait <= n_wait;
            r_ev <= r_s2.ev;
            r_outcome <= r_s2.outcome;
            r_ended <= r_s2.ended;
            r_phase <= r_s2.phase;
            r_sound <= r_s2.sound;
            r_attempts <= r_s2.attempts;
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.event_res = r_ev;
    assign o_out.outcome = r_outcome;
    assign o_out.session_ended = r_ended;
    assign o_out.link_phase = r_phase;
    assign o_out.sound_on = r_sound;
    assign o_out.attempt_count = r_attempts;
    assign o_out.wait_ms = r_wait;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !o_out.ready |-> !i_in.ready)
        else $error("input taken while result stalled");

    a_ended_zero_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_ended |-> r_wait == '0)
        else $error("nonzero wait after session end");
endmodule
